// ----- sv/overcurrent_latch_with_moving_average_unit_defines.svh -----
// Assertion macros for the overcurrent latch with moving average unit
`ifndef OVERCURRENT_LATCH_WITH_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define OVERCURRENT_LATCH_WITH_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define OLMA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define OLMA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/olma_pkg.sv -----
// Shared types and constants for the overcurrent latch with moving average unit
`default_nettype none

package olma_pkg;

    localparam int SAMPLE_W = 16;

    // Configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TRIP     = 2'd0;
    localparam cfg_idx_t REG_CLEAR    = 2'd1;
    localparam cfg_idx_t REG_PERIOD   = 2'd2;
    localparam cfg_idx_t REG_RECOVERY = 2'd3;

    // Operations of the shared accumulate / divide unit
    typedef enum logic [1:0] {
        ALU_HOLD,
        ALU_CLR,
        ALU_ADD,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        alu_op_t               op;
        logic [SAMPLE_W-1:0]   addend;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/olma_if.sv -----
// Request and result channel interfaces
`default_nettype none

interface olma_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_mv;
    logic        sample_valid;
    logic        health_ok;

    modport source (output valid, output sample_mv, output sample_valid,
                    output health_ok, input ready);
    modport sink   (input valid, input sample_mv, input sample_valid,
                    input health_ok, output ready);
endinterface

interface olma_out_if;
    logic        valid;
    logic        ready;
    logic        fault_active;
    logic [15:0] average_mv;
    logic        trip_event;
    logic        recover_event;

    modport source (output valid, output fault_active, output average_mv,
                    output trip_event, output recover_event, input ready);
    modport sink   (input valid, input fault_active, input average_mv,
                    input trip_event, input recover_event, output ready);
endinterface

`default_nettype wire

// ----- sv/olma_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module olma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/olma_alu.sv -----
// Shared accumulate and restoring-divide unit, one add or one quotient bit per cycle
`default_nettype none

module olma_alu #(
    parameter int SW = 20,
    parameter int CW = 4
) (
    input  wire logic                         clk,
    input  wire olma_pkg::alu_ctrl_t          ctrl,
    input  wire logic [CW-1:0]                divisor,
    output logic      [olma_pkg::SAMPLE_W-1:0] quotient
);
    import olma_pkg::*;

    logic [SW-1:0] acc_reg;
    logic [SW-1:0] acc_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [CW:0]   rem_shift;
    logic [CW:0]   div_ext;
    logic          fits;

    // Trial subtract of one restoring division step
    assign rem_shift = {rem_reg, acc_reg[SW-1]};
    assign div_ext   = {1'b0, divisor};
    assign fits      = (rem_shift >= div_ext);

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        case (ctrl.op)
            ALU_CLR:
            begin
                acc_next = '0;
                rem_next = '0;
            end
            ALU_ADD:
            begin
                acc_next = acc_reg + SW'(ctrl.addend);
            end
            ALU_DIV:
            begin
                acc_next = {acc_reg[SW-2:0], fits};
                rem_next = fits ? CW'(rem_shift - div_ext) : CW'(rem_shift);
            end
            default:
            begin
                acc_next = acc_reg;
                rem_next = rem_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    // Mean never exceeds the largest sample, so the low bits hold it whole
    assign quotient = acc_reg[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// ----- sv/overcurrent_latch_with_moving_average_unit.sv -----
// Top level: sample ring, averaging sequencer, fault latch and recovery timer
//
//  channel     dir   handshake        payload
//  sample_in   in    valid / ready    sample_mv, sample_valid, health_ok
//  result_out  out   valid / ready    fault_active, average_mv, trip_event, recover_event
//  apb         in    psel / penable   paddr, pwdata, prdata (pready tied high)
//
// A valid sample passes S_READ, which reads the filled ring entries one at a time
// over the single RAM read port, then S_LAST, then S_DIV, where the divider gives
// one quotient bit per cycle over the SW-bit sum, and S_EVAL loads the result register.
// An invalid sample goes from S_IDLE straight to S_EVAL. Reset clears all control
// state; the ring needs no clearing. A stalled result holds the sequencer in S_EVAL.
`default_nettype none

`include "overcurrent_latch_with_moving_average_unit_defines.svh"

module overcurrent_latch_with_moving_average_unit #(
    parameter int AVG_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    olma_in_if.sink          sample_in,
    olma_out_if.source       result_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import olma_pkg::*;

    localparam int CW  = $clog2(AVG_DEPTH + 1);
    localparam int AW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SW  = SAMPLE_W + CW;
    localparam int DCW = $clog2(SW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_DIV,
        S_EVAL
    } state_t;

    // Configuration registers
    logic [15:0] trip_reg;
    logic [15:0] clear_reg;
    logic [15:0] period_reg;
    logic [15:0] recovery_reg;
    logic        cfg_write;
    cfg_idx_t    cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_reg     <= '0;
            clear_reg    <= '0;
            period_reg   <= 16'd1;
            recovery_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_TRIP:     trip_reg     <= pwdata[15:0];
                REG_CLEAR:    clear_reg    <= pwdata[15:0];
                REG_PERIOD:   period_reg   <= pwdata[15:0];
                REG_RECOVERY: recovery_reg <= pwdata[15:0];
                default:      trip_reg     <= trip_reg;
            endcase
        end
    end

    // Read back configuration
    always_comb
    begin
        case (cfg_idx)
            REG_TRIP:     prdata = {16'd0, trip_reg};
            REG_CLEAR:    prdata = {16'd0, clear_reg};
            REG_PERIOD:   prdata = {16'd0, period_reg};
            REG_RECOVERY: prdata = {16'd0, recovery_reg};
            default:      prdata = '0;
        endcase
    end

    // Sequencer and block state
    state_t          state_reg, state_next;
    logic [CW-1:0]   filled_reg, filled_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [DCW-1:0]  div_cnt_reg, div_cnt_next;
    logic [15:0]     mean_reg, mean_next;
    logic            fault_reg, fault_next;
    logic [15:0]     timer_reg, timer_next;
    logic            valid_l_reg, valid_l_next;
    logic            health_l_reg, health_l_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_fault_reg, out_fault_next;
    logic [15:0]     out_avg_reg, out_avg_next;
    logic            out_trip_reg, out_trip_next;
    logic            out_rec_reg, out_rec_next;

    logic            accept;
    logic            ring_full;
    logic [AW-1:0]   waddr;
    logic            ram_we;
    logic            ram_re;
    logic [15:0]     ram_rdata;
    alu_ctrl_t       alu_ctrl;
    logic [15:0]     quotient;
    logic [16:0]     timer_sum;
    logic [15:0]     timer_sat;

    assign sample_in.ready = (state_reg == S_IDLE);
    assign accept          = sample_in.valid && sample_in.ready;
    assign ring_full       = (filled_reg == CW'(AVG_DEPTH));
    assign waddr           = ring_full ? slot_reg : AW'(filled_reg);
    assign ram_we          = accept && sample_in.sample_valid;
    assign ram_re          = (state_reg == S_READ);

    assign timer_sum = {1'b0, timer_reg} + {1'b0, period_reg};
    assign timer_sat = (timer_sum > {1'b0, recovery_reg}) ? recovery_reg : timer_sum[15:0];

    olma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVG_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (sample_in.sample_mv),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    olma_alu #(
        .SW (SW),
        .CW (CW)
    ) u_alu (
        .clk      (clk),
        .ctrl     (alu_ctrl),
        .divisor  (filled_reg),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        div_cnt_next   = div_cnt_reg;
        mean_next      = mean_reg;
        fault_next     = fault_reg;
        timer_next     = timer_reg;
        valid_l_next   = valid_l_reg;
        health_l_next  = health_l_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_fault_next = out_fault_reg;
        out_avg_next   = out_avg_reg;
        out_trip_next  = out_trip_reg;
        out_rec_next   = out_rec_reg;
        alu_ctrl.op     = ALU_HOLD;
        alu_ctrl.addend = ram_rdata;

        case (state_reg)
            // Take a request; store a valid sample and start the sum
            S_IDLE:
            begin
                if (accept)
                begin
                    valid_l_next  = sample_in.sample_valid;
                    health_l_next = sample_in.health_ok;
                    if (sample_in.sample_valid)
                    begin
                        if (ring_full)
                        begin
                            slot_next = (slot_reg == AW'(AVG_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                        end
                        else
                        begin
                            filled_next = filled_reg + 1'b1;
                        end
                        alu_ctrl.op = ALU_CLR;
                        idx_next    = '0;
                        pend_next   = 1'b0;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            // Issue one ring read a cycle, add the data of the previous read
            S_READ:
            begin
                if (pend_reg)
                begin
                    alu_ctrl.op = ALU_ADD;
                end
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (CW'(idx_reg) == filled_reg - 1'b1)
                begin
                    state_next = S_LAST;
                end
            end
            // Add the last entry and arm the divider
            S_LAST:
            begin
                alu_ctrl.op  = ALU_ADD;
                div_cnt_next = DCW'(SW - 1);
                state_next   = S_DIV;
            end
            // One quotient bit per cycle
            S_DIV:
            begin
                alu_ctrl.op  = ALU_DIV;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_EVAL;
                end
            end
            // Update fault and timer, then load the result register
            S_EVAL:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_trip_next = 1'b0;
                    out_rec_next  = 1'b0;
                    if (!valid_l_reg)
                    begin
                        timer_next = '0;
                    end
                    else
                    begin
                        mean_next = quotient;
                        if (fault_reg)
                        begin
                            if ((quotient <= clear_reg) && health_l_reg)
                            begin
                                if (timer_sat >= recovery_reg)
                                begin
                                    fault_next   = 1'b0;
                                    timer_next   = '0;
                                    out_rec_next = 1'b1;
                                end
                                else
                                begin
                                    timer_next = timer_sat;
                                end
                            end
                            else
                            begin
                                timer_next = '0;
                            end
                        end
                        else if (quotient > trip_reg)
                        begin
                            fault_next    = 1'b1;
                            timer_next    = '0;
                            out_trip_next = 1'b1;
                        end
                    end
                    out_fault_next = fault_next;
                    out_avg_next   = mean_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            filled_reg    <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            mean_reg      <= '0;
            fault_reg     <= 1'b0;
            timer_reg     <= '0;
            valid_l_reg   <= 1'b0;
            health_l_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_fault_reg <= 1'b0;
            out_avg_reg   <= '0;
            out_trip_reg  <= 1'b0;
            out_rec_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            div_cnt_reg   <= div_cnt_next;
            mean_reg      <= mean_next;
            fault_reg     <= fault_next;
            timer_reg     <= timer_next;
            valid_l_reg   <= valid_l_next;
            health_l_reg  <= health_l_next;
            out_valid_reg <= out_valid_next;
            out_fault_reg <= out_fault_next;
            out_avg_reg   <= out_avg_next;
            out_trip_reg  <= out_trip_next;
            out_rec_reg   <= out_rec_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.fault_active  = out_fault_reg;
    assign result_out.average_mv    = out_avg_reg;
    assign result_out.trip_event    = out_trip_reg;
    assign result_out.recover_event = out_rec_reg;

    // Checks
    `OLMA_ASSERT_SAME(a_events_excl, clk, rst_n, result_out.valid, !(result_out.trip_event && result_out.recover_event), "trip and recover in one result")
    `OLMA_ASSERT_SAME(a_trip_fault, clk, rst_n, result_out.valid && result_out.trip_event, result_out.fault_active, "trip without latched fault")
    `OLMA_ASSERT_SAME(a_rec_clear, clk, rst_n, result_out.valid && result_out.recover_event, !result_out.fault_active, "recover with fault still latched")
    `OLMA_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, filled_reg <= CW'(AVG_DEPTH), "ring fill count beyond depth")
    `OLMA_ASSERT_NEXT(a_busy_after, clk, rst_n, accept, !sample_in.ready, "request taken while previous still in work")

endmodule

`default_nettype wire
